/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion helpers shared by the RTL. Each macro expects i_clk and
// i_rst_n in scope and is disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define AST_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define AST_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/aff_pkg.sv */
// ----------------------------------------------------------------------------
// aff_pkg
// Widths and codes of the advertising field finder.
// ----------------------------------------------------------------------------
package aff_pkg;

    localparam int BYTE_W    = 8;
    localparam int CFG_IDX_W = 8;

    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [1:0]        t_code;

    // Parse phase codes
    localparam t_code PHASE_LEN   = 2'd0;
    localparam t_code PHASE_TYPE  = 2'd1;
    localparam t_code PHASE_VALUE = 2'd2;
    localparam t_code PHASE_BAD   = 2'd3;

    // Pending match kinds
    localparam t_code KIND_NONE     = 2'd0;
    localparam t_code KIND_PRIMARY  = 2'd1;
    localparam t_code KIND_FALLBACK = 2'd2;

    // Result status codes
    localparam t_code STATUS_PRIMARY   = 2'd0;
    localparam t_code STATUS_FALLBACK  = 2'd1;
    localparam t_code STATUS_MALFORMED = 2'd2;
    localparam t_code STATUS_ABSENT    = 2'd3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PRIMARY_TYPE  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FALLBACK_TYPE = 8'd1;

    // Reset values of the type registers
    localparam t_byte PRIMARY_TYPE_RST  = 8'h09;
    localparam t_byte FALLBACK_TYPE_RST = 8'h08;

    // Highest payload offset a structure may reach
    localparam t_byte LAST_OFFSET = 8'd254;
    localparam t_byte POS_MAX     = 8'd255;

endpackage

/* rtl/core/adv_field_finder.sv */
// ----------------------------------------------------------------------------
// adv_field_finder
// Walks the length-type-value structures of an advertising payload and
// reports the first primary-type field, else the first fallback-type field.
// ----------------------------------------------------------------------------
// One payload byte is taken per cycle on the input channel, ending with the
// byte flagged last; the result (status, value offset, value length) of that
// payload is registered and shows up on the output channel in the cycle after
// its last byte is transferred. Throughput is one byte per cycle: the parse
// state is computed combinationally from the scan registers, and the result
// register can be reloaded in the same cycle its result is transferred out,
// so payloads can follow each other with no gap. The input stalls only when a
// result is held and the output side is not ready. Type registers are
// written through the config channel, which is always ready; write them only
// while no payload is in flight. Index 0 is the primary type (reset 0x09),
// index 1 the fallback type (reset 0x08); other indexes are ignored.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module adv_field_finder (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // payload byte stream
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [aff_pkg::BYTE_W-1:0]     i_data_byte,
    input  logic                           i_last_byte,
    // result
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [1:0]                     o_status,
    output logic [aff_pkg::BYTE_W-1:0]     o_value_offset,
    output logic [aff_pkg::BYTE_W-1:0]     o_value_length,
    // config writes
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [aff_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [aff_pkg::BYTE_W-1:0]     i_cfg_data
);
    import aff_pkg::*;

    // config
    t_byte r_primary_type,  n_primary_type;
    t_byte r_fallback_type, n_fallback_type;

    // scan state
    t_byte r_byte_position,   n_byte_position;
    t_byte r_field_left,      n_field_left;
    t_code r_phase,           n_phase;
    t_code r_pend_kind,       n_pend_kind;
    t_byte r_pend_offset,     n_pend_offset;
    t_byte r_pend_length,     n_pend_length;
    logic  r_primary_hit,     n_primary_hit;
    t_byte r_primary_offset,  n_primary_offset;
    t_byte r_primary_length,  n_primary_length;
    logic  r_fallback_hit,    n_fallback_hit;
    t_byte r_fallback_offset, n_fallback_offset;
    t_byte r_fallback_length, n_fallback_length;
    logic  r_scan_stopped,    n_scan_stopped;

    // result register
    logic  r_out_valid, n_out_valid;
    t_code r_status,    n_status;
    t_byte r_offset,    n_offset;
    t_byte r_length,    n_length;

    logic         in_xfer;
    logic         do_commit;
    t_byte        left_dec;
    logic [8:0]   end_pos;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_xfer     = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_value_offset = r_offset;
    assign o_value_length = r_length;

    assign left_dec = r_field_left - 8'd1;
    // end offset of a new structure, one bit wider so it cannot wrap
    assign end_pos  = {1'b0, r_byte_position} + {1'b0, i_data_byte};

    // config write
    always_comb begin
        n_primary_type  = r_primary_type;
        n_fallback_type = r_fallback_type;
        if (i_cfg_valid) begin
            if (i_cfg_index == CFG_PRIMARY_TYPE) begin
                n_primary_type = i_cfg_data;
            end else if (i_cfg_index == CFG_FALLBACK_TYPE) begin
                n_fallback_type = i_cfg_data;
            end
        end
    end

    // parser step for one accepted byte
    always_comb begin
        n_byte_position   = r_byte_position;
        n_field_left      = r_field_left;
        n_phase           = r_phase;
        n_pend_kind       = r_pend_kind;
        n_pend_offset     = r_pend_offset;
        n_pend_length     = r_pend_length;
        n_primary_hit     = r_primary_hit;
        n_primary_offset  = r_primary_offset;
        n_primary_length  = r_primary_length;
        n_fallback_hit    = r_fallback_hit;
        n_fallback_offset = r_fallback_offset;
        n_fallback_length = r_fallback_length;
        n_scan_stopped    = r_scan_stopped;
        n_out_valid       = r_out_valid && !i_out_ready;
        n_status          = r_status;
        n_offset          = r_offset;
        n_length          = r_length;
        do_commit         = 1'b0;

        if (in_xfer) begin
            if (!r_scan_stopped && r_phase != PHASE_BAD) begin
                unique case (r_phase)
                    PHASE_LEN: begin
                        // a length byte alone at the end is ignored
                        if (!i_last_byte) begin
                            if (i_data_byte == '0) begin
                                n_scan_stopped = 1'b1;
                            end else if (end_pos > {1'b0, LAST_OFFSET}) begin
                                n_phase = PHASE_BAD;
                            end else begin
                                n_field_left = i_data_byte;
                                n_phase      = PHASE_TYPE;
                            end
                        end
                    end
                    PHASE_TYPE: begin
                        // primary wins when both types match
                        if (i_data_byte == r_primary_type && !r_primary_hit) begin
                            n_pend_kind = KIND_PRIMARY;
                        end else if (i_data_byte == r_fallback_type &&
                                     !r_fallback_hit) begin
                            n_pend_kind = KIND_FALLBACK;
                        end else begin
                            n_pend_kind = KIND_NONE;
                        end
                        n_pend_offset = r_byte_position + 8'd1;
                        n_pend_length = left_dec;
                        n_field_left  = left_dec;
                        if (left_dec == '0) begin
                            do_commit = 1'b1;
                        end else begin
                            n_phase = PHASE_VALUE;
                        end
                    end
                    default: begin
                        n_field_left = left_dec;
                        if (left_dec == '0) begin
                            do_commit = 1'b1;
                        end
                    end
                endcase

                if (do_commit) begin
                    if (n_pend_kind == KIND_PRIMARY && !r_primary_hit) begin
                        n_primary_hit    = 1'b1;
                        n_primary_offset = n_pend_offset;
                        n_primary_length = n_pend_length;
                    end else if (n_pend_kind == KIND_FALLBACK && !r_fallback_hit) begin
                        n_fallback_hit    = 1'b1;
                        n_fallback_offset = n_pend_offset;
                        n_fallback_length = n_pend_length;
                    end
                    n_pend_kind = KIND_NONE;
                    n_phase     = PHASE_LEN;
                end

                // structure cut short by the end of the payload
                if (i_last_byte && (n_phase == PHASE_TYPE || n_phase == PHASE_VALUE)) begin
                    n_phase     = PHASE_BAD;
                    n_pend_kind = KIND_NONE;
                end
            end

            if (r_byte_position != POS_MAX) begin
                n_byte_position = r_byte_position + 8'd1;
            end

            if (i_last_byte) begin
                n_out_valid = 1'b1;
                priority if (n_primary_hit) begin
                    n_status = STATUS_PRIMARY;
                    n_offset = n_primary_offset;
                    n_length = n_primary_length;
                end else if (n_fallback_hit) begin
                    n_status = STATUS_FALLBACK;
                    n_offset = n_fallback_offset;
                    n_length = n_fallback_length;
                end else if (n_phase == PHASE_BAD) begin
                    n_status = STATUS_MALFORMED;
                    n_offset = '0;
                    n_length = '0;
                end else begin
                    n_status = STATUS_ABSENT;
                    n_offset = '0;
                    n_length = '0;
                end

                // fresh scan for the next payload
                n_byte_position   = '0;
                n_field_left      = '0;
                n_phase           = PHASE_LEN;
                n_pend_kind       = KIND_NONE;
                n_pend_offset     = '0;
                n_pend_length     = '0;
                n_primary_hit     = 1'b0;
                n_primary_offset  = '0;
                n_primary_length  = '0;
                n_fallback_hit    = 1'b0;
                n_fallback_offset = '0;
                n_fallback_length = '0;
                n_scan_stopped    = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_primary_type    <= PRIMARY_TYPE_RST;
            r_fallback_type   <= FALLBACK_TYPE_RST;
            r_byte_position   <= '0;
            r_field_left      <= '0;
            r_phase           <= PHASE_LEN;
            r_pend_kind       <= KIND_NONE;
            r_pend_offset     <= '0;
            r_pend_length     <= '0;
            r_primary_hit     <= 1'b0;
            r_primary_offset  <= '0;
            r_primary_length  <= '0;
            r_fallback_hit    <= 1'b0;
            r_fallback_offset <= '0;
            r_fallback_length <= '0;
            r_scan_stopped    <= 1'b0;
            r_out_valid       <= 1'b0;
        end else begin
            r_primary_type    <= n_primary_type;
            r_fallback_type   <= n_fallback_type;
            r_byte_position   <= n_byte_position;
            r_field_left      <= n_field_left;
            r_phase           <= n_phase;
            r_pend_kind       <= n_pend_kind;
            r_pend_offset     <= n_pend_offset;
            r_pend_length     <= n_pend_length;
            r_primary_hit     <= n_primary_hit;
            r_primary_offset  <= n_primary_offset;
            r_primary_length  <= n_primary_length;
            r_fallback_hit    <= n_fallback_hit;
            r_fallback_offset <= n_fallback_offset;
            r_fallback_length <= n_fallback_length;
            r_scan_stopped    <= n_scan_stopped;
            r_out_valid       <= n_out_valid;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_offset <= n_offset;
        r_length <= n_length;
    end

    // ---- assertions ----
    `AST_NEXT(a_last_gives_result, in_xfer && i_last_byte, r_out_valid,
        "last byte transfer did not produce a result")
    `AST_NEXT(a_last_clears_scan, in_xfer && i_last_byte,
        r_byte_position == '0 && !r_primary_hit && !r_fallback_hit,
        "scan state not cleared after last byte")
    `AST_NOW(a_no_match_zero_fields,
        r_out_valid && (r_status == STATUS_MALFORMED || r_status == STATUS_ABSENT),
        r_offset == '0 && r_length == '0,
        "malformed or absent result carries nonzero offset or length")
    `AST_NOW(a_type_phase_len, r_phase == PHASE_TYPE, r_field_left != '0,
        "type phase entered with zero structure length")

endmodule

/* verif/adv_field_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adv_field_checker
// Watches the payload, result and type register channels of the advertising
// field finder, walks every transferred payload byte through its own model
// of the structure scan, and compares each result transfer field by field
// with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module adv_field_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  aff_pkg::t_byte                 i_data_byte,
    input  logic                           i_last_byte,
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  aff_pkg::t_code                 i_status,
    input  aff_pkg::t_byte                 i_value_offset,
    input  aff_pkg::t_byte                 i_value_length,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [aff_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  aff_pkg::t_byte                 i_cfg_data,
    output int                             o_errors,
    output int                             o_reports_due
);
    import aff_pkg::*;

    typedef struct packed {
        t_code status;
        t_byte offset;
        t_byte length;
    } field_report_t;

    // type registers as last written
    t_byte primary_sel;
    t_byte fallback_sel;

    // scan state of the payload in flight
    t_byte walk_pos;
    t_byte left_in_field;
    t_code walk_phase;
    t_code cand_kind;
    t_byte cand_offset;
    t_byte cand_length;
    logic  primary_seen;
    t_byte primary_off;
    t_byte primary_len;
    logic  fallback_seen;
    t_byte fallback_off;
    t_byte fallback_len;
    logic  walk_stopped;

    field_report_t reports_due[$];

    task automatic note_mismatch(input string what, input int got, input int want);
        $display("%0t ns: mismatch on %s: got %0d, want %0d", $time, what, got, want);
        o_errors = o_errors + 1;
    endtask

    task automatic clear_walk();
        walk_pos      = '0;
        left_in_field = '0;
        walk_phase    = PHASE_LEN;
        cand_kind     = KIND_NONE;
        cand_offset   = '0;
        cand_length   = '0;
        primary_seen  = 1'b0;
        primary_off   = '0;
        primary_len   = '0;
        fallback_seen = 1'b0;
        fallback_off  = '0;
        fallback_len  = '0;
        walk_stopped  = 1'b0;
    endtask

    // end of a complete structure: keep it if it is the first of its kind
    task automatic close_field();
        if (cand_kind == KIND_PRIMARY && !primary_seen) begin
            primary_seen = 1'b1;
            primary_off  = cand_offset;
            primary_len  = cand_length;
        end else if (cand_kind == KIND_FALLBACK && !fallback_seen) begin
            fallback_seen = 1'b1;
            fallback_off  = cand_offset;
            fallback_len  = cand_length;
        end
        cand_kind  = KIND_NONE;
        walk_phase = PHASE_LEN;
    endtask

    task automatic walk_byte(input t_byte d, input logic last);
        field_report_t rpt;
        if (!walk_stopped && walk_phase != PHASE_BAD) begin
            case (walk_phase)
                PHASE_LEN: begin
                    // a length byte that is also the last byte is ignored
                    if (!last) begin
                        if (d == '0) begin
                            walk_stopped = 1'b1;
                        end else if (int'(walk_pos) + int'(d) > int'(LAST_OFFSET)) begin
                            walk_phase = PHASE_BAD;
                        end else begin
                            left_in_field = d;
                            walk_phase    = PHASE_TYPE;
                        end
                    end
                end
                PHASE_TYPE: begin
                    if (d == primary_sel && !primary_seen)
                        cand_kind = KIND_PRIMARY;
                    else if (d == fallback_sel && !fallback_seen)
                        cand_kind = KIND_FALLBACK;
                    else
                        cand_kind = KIND_NONE;
                    cand_offset   = walk_pos + 8'd1;
                    cand_length   = left_in_field - 8'd1;
                    left_in_field = left_in_field - 8'd1;
                    if (left_in_field == '0)
                        close_field();
                    else
                        walk_phase = PHASE_VALUE;
                end
                default: begin
                    left_in_field = left_in_field - 8'd1;
                    if (left_in_field == '0)
                        close_field();
                end
            endcase
            // structure cut short by the end of the payload
            if (last && (walk_phase == PHASE_TYPE || walk_phase == PHASE_VALUE)) begin
                walk_phase = PHASE_BAD;
                cand_kind  = KIND_NONE;
            end
        end

        if (walk_pos != POS_MAX)
            walk_pos = walk_pos + 8'd1;

        if (last) begin
            rpt.offset = '0;
            rpt.length = '0;
            if (primary_seen) begin
                rpt.status = STATUS_PRIMARY;
                rpt.offset = primary_off;
                rpt.length = primary_len;
            end else if (fallback_seen) begin
                rpt.status = STATUS_FALLBACK;
                rpt.offset = fallback_off;
                rpt.length = fallback_len;
            end else if (walk_phase == PHASE_BAD) begin
                rpt.status = STATUS_MALFORMED;
            end else begin
                rpt.status = STATUS_ABSENT;
            end
            reports_due.push_back(rpt);
            clear_walk();
        end
    endtask

    always @(posedge i_clk) begin
        field_report_t want;
        if (!i_rst_n) begin
            primary_sel  = PRIMARY_TYPE_RST;
            fallback_sel = FALLBACK_TYPE_RST;
            clear_walk();
            reports_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_PRIMARY_TYPE:  primary_sel  = i_cfg_data;
                    CFG_FALLBACK_TYPE: fallback_sel = i_cfg_data;
                    default: ;
                endcase
            end
            // compare before queuing: a result leaving now belongs to an older payload
            if (i_out_valid && i_out_ready) begin
                if (reports_due.size() == 0) begin
                    note_mismatch("unexpected result, status", int'(i_status), -1);
                end else begin
                    want = reports_due.pop_front();
                    if (i_status !== want.status)
                        note_mismatch("status", int'(i_status), int'(want.status));
                    if (i_value_offset !== want.offset)
                        note_mismatch("value_offset", int'(i_value_offset),
                                      int'(want.offset));
                    if (i_value_length !== want.length)
                        note_mismatch("value_length", int'(i_value_length),
                                      int'(want.length));
                end
            end
            if (i_in_valid && i_in_ready)
                walk_byte(i_data_byte, i_last_byte);
        end
        o_reports_due <= reports_due.size();
    end

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the advertising field finder. A short directed
// set of payloads is followed by six phases of random payloads, each phase
// under its own pair of type registers; a separate checker predicts and
// compares every result.
// ----------------------------------------------------------------------------
module tb;
    import aff_pkg::*;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int RANDOM_BYTES    = 1550;
    localparam int N_PHASES        = 6;
    localparam int HOLD_OFF_CYCLES = 400;
    // settling margin after the result of the last byte is registered
    localparam int SETTLE_CYCLES   = 8;
    localparam int MAX_GAP         = 16;

    logic                 clk;
    logic                 rst_n      = 1'b0;
    logic                 in_valid   = 1'b0;
    logic                 in_ready;
    t_byte                data_byte  = '0;
    logic                 last_byte  = 1'b0;
    logic                 out_valid;
    logic                 out_ready  = 1'b0;
    t_code                status;
    t_byte                value_offset;
    t_byte                value_length;
    logic                 cfg_valid  = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index  = '0;
    t_byte                cfg_data   = '0;

    int errors;
    int reports_due;
    int cycles;
    int sent_bytes   = 0;

    // stimulus-side copy of the type registers, used to aim field types
    t_byte prim_cfg  = PRIMARY_TYPE_RST;
    t_byte fall_cfg  = FALLBACK_TYPE_RST;

    // bytes of the payload being built
    t_byte pl_bytes[$];

    logic sender_quiet  = 1'b0;
    logic sink_quiet    = 1'b0;
    logic hold_off_req  = 1'b0;

    adv_field_finder dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_data_byte    (data_byte),
        .i_last_byte    (last_byte),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_status       (status),
        .o_value_offset (value_offset),
        .o_value_length (value_length),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    adv_field_checker checker_i (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_data_byte    (data_byte),
        .i_last_byte    (last_byte),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_status       (status),
        .i_value_offset (value_offset),
        .i_value_length (value_length),
        .i_cfg_valid    (cfg_valid),
        .i_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .o_errors       (errors),
        .o_reports_due  (reports_due)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Watchdog: a hung handshake or a missing result ends here.
    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles = cycles + 1;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------
    // Byte sender. Valid goes high after a random gap and stays high with
    // the same byte until the transfer. With a zero gap it simply stays
    // high for the next byte, so valid is never dropped and raised in the
    // same step.
    // ------------------------------------------------------------------
    task automatic send_byte(input t_byte d, input logic last);
        int gap;
        gap = sender_quiet ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= d;
        last_byte <= last;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sent_bytes = sent_bytes + 1;
    endtask

    // Sends pl_bytes, last flag on the final byte. About one payload in four
    // goes back to back so the block sees long runs of full-rate input.
    task automatic send_payload();
        sender_quiet = ($urandom_range(0, 3) == 0);
        foreach (pl_bytes[k])
            send_byte(pl_bytes[k], k == pl_bytes.size() - 1);
    endtask

    // Directed payloads come as a packed vector, first byte in the top lane.
    task automatic send_directed(input int n, input logic [63:0] seq);
        pl_bytes.delete();
        for (int k = 0; k < n; k++)
            pl_bytes.push_back(seq[8*(n-1-k) +: 8]);
        send_payload();
    endtask

    // ------------------------------------------------------------------
    // Payload builders
    // ------------------------------------------------------------------
    // Field type aimed at the registers most of the time.
    function automatic t_byte pick_type();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return prim_cfg;
        if (r < 65)
            return fall_cfg;
        return t_byte'($urandom);
    endfunction

    // Field type that matches neither register.
    function automatic t_byte other_type();
        t_byte t;
        t = t_byte'($urandom);
        while (t == prim_cfg || t == fall_cfg)
            t = t_byte'($urandom);
        return t;
    endfunction

    // One complete structure: length byte, type byte, len-1 value bytes.
    task automatic add_field(input int len, input t_byte kind);
        pl_bytes.push_back(t_byte'(len));
        pl_bytes.push_back(kind);
        repeat (len - 1) pl_bytes.push_back(t_byte'($urandom));
    endtask

    // Well-formed structures, sometimes followed by a broken tail.
    task automatic build_regular();
        int n_fields;
        int len;
        int cut;
        pl_bytes.delete();
        n_fields = $urandom_range(0, 4);
        repeat (n_fields) begin
            // short fields often, so empty and one-byte values show up
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : $urandom_range(1, 12);
            add_field(len, pick_type());
        end
        case ($urandom_range(0, 9))
            0: begin
                // dangling length byte at the end: ignored
                pl_bytes.push_back(t_byte'($urandom_range(1, 255)));
            end
            1: begin
                // zero length stops the scan, anything after it is ignored
                pl_bytes.push_back(8'h00);
                repeat ($urandom_range(0, 3)) pl_bytes.push_back(t_byte'($urandom));
            end
            2: begin
                // structure cut short by the last byte
                len = $urandom_range(2, 20);
                cut = $urandom_range(1, len - 1);
                pl_bytes.push_back(t_byte'(len));
                pl_bytes.push_back(pick_type());
                repeat (cut - 1) pl_bytes.push_back(t_byte'($urandom));
            end
            3: begin
                // length 255 always runs past the payload
                pl_bytes.push_back(8'hFF);
                repeat ($urandom_range(1, 3)) pl_bytes.push_back(t_byte'($urandom));
            end
            default: ;
        endcase
        if (pl_bytes.size() == 0)
            add_field($urandom_range(1, 5), pick_type());
    endtask

    // Plain random bytes: mostly overruns and truncations.
    task automatic build_noise();
        pl_bytes.delete();
        repeat ($urandom_range(1, 24)) pl_bytes.push_back(t_byte'($urandom));
    endtask

    // Long payload: 23 filler structures of 11 bytes put the next length
    // byte at offset 253, then one of four tails:
    //   0: one-byte structure whose type sits at 254, value offset 255
    //   1: two-byte structure at 253, just past the end limit
    //   2: one-byte structure, then a nonzero length at the saturated offset
    //   3: one-byte structure, then a zero length at the saturated offset
    task automatic build_long(input int tail);
        pl_bytes.delete();
        repeat (23) begin
            if (tail != 0 && $urandom_range(0, 4) == 0)
                add_field(10, pick_type());
            else
                add_field(10, other_type());
        end
        if (tail == 1) begin
            add_field(2, pick_type());
        end else begin
            add_field(1, pick_type());
            if (tail == 2)
                pl_bytes.push_back(t_byte'($urandom_range(1, 255)));
            if (tail == 3)
                pl_bytes.push_back(8'h00);
            if (tail >= 2)
                repeat ($urandom_range(1, 3)) pl_bytes.push_back(t_byte'($urandom));
        end
    endtask

    // ------------------------------------------------------------------
    // Idle handling and register writes
    // ------------------------------------------------------------------
    // Drop valid, wait for every predicted result, then let the block settle.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (reports_due != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One register transfer; valid is left high for back-to-back writes.
    task automatic cfg_push(input logic [CFG_IDX_W-1:0] idx, input t_byte val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    // Phase settings: both extremes, swapped extremes, equal types, reset
    // values again, then random pairs. Each phase also writes a junk index
    // that must be ignored.
    task automatic configure(input int ph);
        t_byte p;
        t_byte f;
        logic [CFG_IDX_W-1:0] junk_idx;
        junk_idx = CFG_IDX_W'($urandom_range(2, 255));
        case (ph)
            0: begin
                p = 8'h00;
                f = 8'hFF;
                junk_idx = '1;
            end
            1: begin
                p = 8'hFF;
                f = 8'h00;
            end
            2: begin
                p = t_byte'($urandom);
                f = p;
            end
            3: begin
                p = PRIMARY_TYPE_RST;
                f = FALLBACK_TYPE_RST;
            end
            default: begin
                p = t_byte'($urandom);
                f = t_byte'($urandom);
            end
        endcase
        prim_cfg = p;
        fall_cfg = f;
        cfg_push(junk_idx, t_byte'($urandom));
        cfg_push(CFG_PRIMARY_TYPE, p);
        cfg_push(CFG_FALLBACK_TYPE, f);
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Result sink. Draws a stall per result, flips into runs of no stalls
    // now and then, and on request holds ready low for a long stretch
    // while the sender keeps offering bytes, so the block backs up.
    // ------------------------------------------------------------------
    initial begin : result_sink
        int stall;
        wait (rst_n);
        @(posedge clk);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end else begin
                if ($urandom_range(0, 7) == 0)
                    sink_quiet = !sink_quiet;
                stall = sink_quiet ? 0 : $urandom_range(0, MAX_GAP);
                if (stall > 0) begin
                    out_ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        int random_base;
        int tail;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed payloads under the reset type registers.
        // primary field, value at offset 2, two bytes
        send_directed(4, 64'({8'd3, PRIMARY_TYPE_RST, 8'h41, 8'h42}));
        // fallback field only
        send_directed(3, 64'({8'd2, FALLBACK_TYPE_RST, 8'h55}));
        // primary wins over an earlier fallback
        send_directed(7, 64'({8'd2, FALLBACK_TYPE_RST, 8'h11, 8'd3, PRIMARY_TYPE_RST,
                              8'h22, 8'h33}));
        // lone length byte: absent
        send_directed(1, 64'({8'hFF}));
        // structure cut short by the last byte: malformed
        send_directed(3, 64'({8'd5, PRIMARY_TYPE_RST, 8'h01}));
        // length 255 overruns
        send_directed(3, 64'({8'hFF, PRIMARY_TYPE_RST, 8'h00}));
        // zero length stops the scan; the fallback found before it stands
        send_directed(5, 64'({8'd2, FALLBACK_TYPE_RST, 8'h12, 8'h00, PRIMARY_TYPE_RST}));
        // primary with an empty value
        send_directed(2, 64'({8'd1, PRIMARY_TYPE_RST}));
        // lone zero byte
        send_directed(1, 64'({8'h00}));

        random_base = sent_bytes;
        for (int ph = 0; ph < N_PHASES; ph++) begin
            drain();
            configure(ph);
            if (ph == 1)
                hold_off_req = 1'b1;
            // three long payloads in all: they cost about 255 bytes each
            if (ph % 2 == 0) begin
                if (ph == 0)
                    tail = 0;
                else if (ph == 2)
                    tail = 2;
                else
                    tail = ($urandom_range(0, 1) == 0) ? 1 : 3;
                build_long(tail);
                send_payload();
            end
            while (sent_bytes - random_base < (ph + 1) * RANDOM_BYTES / N_PHASES) begin
                if ($urandom_range(0, 99) < 80)
                    build_regular();
                else
                    build_noise();
                send_payload();
            end
        end

        drain();
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/aff_pkg.sv
rtl/core/adv_field_finder.sv
verif/adv_field_checker.sv
verif/tb.sv
